// ===== src/lrqm_pkg.sv =====
// Shared constants, types and helpers of the linked request queue manager.
package lrqm_pkg;

	localparam int SLOTS      = 256;
	localparam int CHANNELS   = 8;
	localparam int WAYS       = 8;

	localparam int SW         = $clog2(SLOTS);
	localparam int LW         = SW + 1;
	localparam int CW         = $clog2(SLOTS + 1);
	localparam int ROW_BASE   = 4;
	localparam int FLASH_BASE = 4 + CHANNELS * WAYS;
	localparam int QCOUNT     = 4 + 2 * CHANNELS * WAYS;
	localparam int QW         = $clog2(QCOUNT);
	localparam int CLR_N      = (SLOTS > QCOUNT) ? SLOTS : QCOUNT;
	localparam int CLRW       = $clog2(CLR_N);

	localparam logic [LW-1:0] LINK_NONE = LW'(1) << SW;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_UNLINK = 2'd2;

	localparam logic [2:0] CL_FREE  = 3'd0;
	localparam logic [2:0] CL_SLICE = 3'd1;
	localparam logic [2:0] CL_BUF   = 3'd2;
	localparam logic [2:0] CL_ROW   = 3'd3;
	localparam logic [2:0] CL_DMA   = 3'd4;
	localparam logic [2:0] CL_FLASH = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NALLOWED = 2'd2;

	localparam logic [2:0] K_NONE  = 3'd0;
	localparam logic [2:0] K_FREE  = 3'd1;
	localparam logic [2:0] K_SLICE = 3'd2;
	localparam logic [2:0] K_BUF   = 3'd3;
	localparam logic [2:0] K_ROW   = 3'd4;
	localparam logic [2:0] K_DMA   = 3'd5;
	localparam logic [2:0] K_FLASH = 3'd6;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] queue_class;
		logic [2:0] channel;
		logic [2:0] way;
		logic [7:0] slot;
	} cmd_t;

	typedef struct packed {
		logic [7:0] result_slot;
		logic [1:0] status;
		logic [8:0] queue_count;
		logic [8:0] blocked_total;
		logic [8:0] flash_outstanding;
	} rsp_t;

	typedef struct packed {
		logic [LW-1:0] head;
		logic [LW-1:0] tail;
		logic [CW-1:0] size;
	} qent_t;

	typedef struct packed {
		logic          ok;
		logic [QW-1:0] idx;
	} qsel_t;

	function automatic logic [2:0] kind_of_class(input logic [2:0] cls);
		logic [2:0] k;
		case (cls)
			CL_FREE:  k = K_FREE;
			CL_SLICE: k = K_SLICE;
			CL_BUF:   k = K_BUF;
			CL_ROW:   k = K_ROW;
			CL_DMA:   k = K_DMA;
			CL_FLASH: k = K_FLASH;
			default:  k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic qsel_t queue_index(input logic [2:0] cls, input logic [2:0] ch,
		input logic [2:0] way);
		qsel_t r;
		r.ok  = 1'b1;
		r.idx = '0;
		case (cls)
			CL_FREE:  r.idx = QW'(0);
			CL_SLICE: r.idx = QW'(1);
			CL_BUF:   r.idx = QW'(2);
			CL_DMA:   r.idx = QW'(3);
			CL_ROW, CL_FLASH: begin
				if (int'(ch) < CHANNELS && int'(way) < WAYS) begin
					r.idx = QW'(((cls == CL_ROW) ? ROW_BASE : FLASH_BASE)
						+ int'(ch) * WAYS + int'(way));
				end else begin
					r.ok = 1'b0;
				end
			end
			default: r.ok = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/linked_request_queue_manager_unit.sv =====
// Top level of the linked request queue manager: sequencer around the link and queue RAMs.
//
// Usage: drive cmd and raise start while busy is low; the item is taken at that
// clock edge. Each item gives exactly one result on rsp, marked by done for a
// single cycle; the receiver cannot hold it off and must take it then.
// Item path from the accept edge to done, state by state:
//   append: S_CHK, S_FA, then S_FA2 if the queue was not empty, S_DONE;
//   pop of the free or slice queue: S_CHK, S_POP, S_DONE; rejected item: S_CHK, S_DONE;
//   unlink from a blocked queue: S_CHK, S_DONE; from the DMA queue: as an append;
//   pop of a flash queue: S_CHK, S_POP, S_FA, S_FA2 if free queue not empty, S_DONE.
// busy falls in the cycle after done, so the next item is taken only after the
// last one has given its result. The sequence of states follows from the registered read
// data of the link RAMs (next, prev, kind) and of the queue head/tail/size RAM: every
// link step is a read followed by a dependent write.
// After reset the block sweeps all RAMs back to the free-pool layout, one entry
// a cycle, holding busy high meanwhile.
module linked_request_queue_manager_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lrqm_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done,
	output lrqm_pkg::rsp_t rsp
);
	import lrqm_pkg::*;

	typedef enum logic [6:0] {
		S_CLR  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_CHK  = 7'b0000100,
		S_POP  = 7'b0001000,
		S_FA   = 7'b0010000,
		S_FA2  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [CLRW-1:0] clr_q;
	logic [1:0]      op_q;
	logic [2:0]      cls_q;
	logic            qok_q;
	logic            sok_q;
	logic [QW-1:0]   qidx_q;
	logic [SW-1:0]   s_q;
	logic [QW-1:0]   aq_q;
	logic [2:0]      ak_q;
	logic [LW-1:0]   tail_q;
	logic [SW-1:0]   rs_q;
	logic [1:0]      st_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   blk_q;
	logic [CW-1:0]   fl_q;

	logic          nx_we, pv_we, kd_we, qm_we;
	logic [SW-1:0] nx_wa, pv_wa, kd_wa, nx_ra, pv_ra, kd_ra;
	logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
	logic [2:0]    kd_wd, kd_rd;
	logic [QW-1:0] qm_wa, qm_ra;
	qent_t         qm_wd;
	logic [2*LW+CW-1:0] qm_rd;
	qent_t         qe;
	qsel_t         qsel;

	logic app_ok, pop_cls, pop_go, pop_empty, unl_ok;

	lrqm_ram #(.W(LW), .D(SLOTS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
	);
	lrqm_ram #(.W(LW), .D(SLOTS)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd)
	);
	lrqm_ram #(.W(3), .D(SLOTS)) u_kind (
		.clk(clk), .we(kd_we), .waddr(kd_wa), .wdata(kd_wd), .raddr(kd_ra), .rdata(kd_rd)
	);
	lrqm_ram #(.W(2*LW+CW), .D(QCOUNT)) u_queue (
		.clk(clk), .we(qm_we), .waddr(qm_wa), .wdata(qm_wd), .raddr(qm_ra), .rdata(qm_rd)
	);

	assign qe   = qent_t'(qm_rd);
	assign qsel = queue_index(cmd.queue_class, cmd.channel, cmd.way);

	assign app_ok = qok_q && op_q == OP_APPEND && sok_q && kd_rd == K_NONE;
	assign pop_cls = cls_q == CL_FREE || cls_q == CL_SLICE || cls_q == CL_FLASH;
	assign pop_go = qok_q && op_q == OP_POP && pop_cls && !qe.head[SW];
	assign pop_empty = qok_q && op_q == OP_POP && pop_cls && qe.head[SW];
	assign unl_ok = qok_q && op_q == OP_UNLINK
		&& (cls_q == CL_BUF || cls_q == CL_ROW || cls_q == CL_DMA)
		&& sok_q && kd_rd == kind_of_class(cls_q) && qe.size != '0
		&& (!pv_rd[SW] || qe.head == {1'b0, s_q})
		&& (!nx_rd[SW] || qe.tail == {1'b0, s_q});

	always_comb begin
		nx_we = 1'b0;
		nx_wa = s_q;
		nx_wd = LINK_NONE;
		pv_we = 1'b0;
		pv_wa = s_q;
		pv_wd = LINK_NONE;
		kd_we = 1'b0;
		kd_wa = s_q;
		kd_wd = K_NONE;
		qm_we = 1'b0;
		qm_wa = qidx_q;
		qm_wd = qe;
		nx_ra = s_q;
		pv_ra = s_q;
		kd_ra = s_q;
		qm_ra = qidx_q;
		case (state_q)
			S_CLR: begin
				nx_we = int'(clr_q) < SLOTS;
				pv_we = int'(clr_q) < SLOTS;
				kd_we = int'(clr_q) < SLOTS;
				nx_wa = clr_q[SW-1:0];
				pv_wa = clr_q[SW-1:0];
				kd_wa = clr_q[SW-1:0];
				nx_wd = (int'(clr_q) == SLOTS - 1) ? LINK_NONE : LW'(clr_q) + LW'(1);
				pv_wd = (clr_q == '0) ? LINK_NONE : LW'(clr_q) - LW'(1);
				kd_wd = K_FREE;
				qm_we = int'(clr_q) < QCOUNT;
				qm_wa = clr_q[QW-1:0];
				if (clr_q == '0) begin
					qm_wd.head = LW'(0);
					qm_wd.tail = LW'(SLOTS - 1);
					qm_wd.size = CW'(SLOTS);
				end else begin
					qm_wd.head = LINK_NONE;
					qm_wd.tail = LINK_NONE;
					qm_wd.size = '0;
				end
			end
			S_IDLE: begin
				nx_ra = cmd.slot[SW-1:0];
				pv_ra = cmd.slot[SW-1:0];
				kd_ra = cmd.slot[SW-1:0];
				qm_ra = qsel.idx;
			end
			S_CHK: begin
				qm_ra = (op_q == OP_UNLINK) ? QW'(0) : qidx_q;
				nx_ra = (op_q == OP_POP) ? qe.head[SW-1:0] : s_q;
				if (unl_ok) begin
					if (!pv_rd[SW]) begin
						nx_we = 1'b1;
						nx_wa = pv_rd[SW-1:0];
						nx_wd = nx_rd;
					end
					if (!nx_rd[SW]) begin
						pv_we = 1'b1;
						pv_wa = nx_rd[SW-1:0];
						pv_wd = pv_rd;
					end
					qm_we      = 1'b1;
					qm_wd.head = pv_rd[SW] ? nx_rd : qe.head;
					qm_wd.tail = nx_rd[SW] ? pv_rd : qe.tail;
					qm_wd.size = qe.size - CW'(1);
					kd_we      = cls_q != CL_DMA;
				end
			end
			S_POP: begin
				qm_ra      = QW'(0);
				qm_we      = 1'b1;
				qm_wd.head = nx_rd;
				qm_wd.tail = nx_rd[SW] ? LINK_NONE : qe.tail;
				qm_wd.size = qe.size - CW'(1);
				if (!nx_rd[SW]) begin
					pv_we = 1'b1;
					pv_wa = nx_rd[SW-1:0];
				end
				kd_we = cls_q != CL_FLASH;
			end
			S_FA: begin
				qm_we      = 1'b1;
				qm_wa      = aq_q;
				qm_wd.head = qe.tail[SW] ? {1'b0, s_q} : qe.head;
				qm_wd.tail = {1'b0, s_q};
				qm_wd.size = qe.size + CW'(1);
				pv_we      = 1'b1;
				pv_wd      = qe.tail;
				nx_we      = 1'b1;
				kd_we      = 1'b1;
				kd_wd      = ak_q;
			end
			S_FA2: begin
				nx_we = 1'b1;
				nx_wa = tail_q[SW-1:0];
				nx_wd = {1'b0, s_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			blk_q   <= '0;
			fl_q    <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CLRW'(1);
					if (int'(clr_q) == CLR_N - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= cmd.kind;
						cls_q   <= cmd.queue_class;
						qok_q   <= qsel.ok;
						qidx_q  <= qsel.idx;
						s_q     <= cmd.slot[SW-1:0];
						sok_q   <= int'(cmd.slot) < SLOTS;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					rs_q    <= '0;
					st_q    <= ST_NALLOWED;
					cnt_q   <= qok_q ? qe.size : '0;
					state_q <= S_DONE;
					if (app_ok) begin
						aq_q    <= qidx_q;
						ak_q    <= kind_of_class(cls_q);
						state_q <= S_FA;
					end else if (pop_go) begin
						s_q     <= qe.head[SW-1:0];
						state_q <= S_POP;
					end else if (pop_empty) begin
						st_q <= ST_EMPTY;
					end else if (unl_ok) begin
						cnt_q <= qe.size - CW'(1);
						st_q  <= ST_OK;
						rs_q  <= s_q;
						if (cls_q != CL_DMA) begin
							if (blk_q != '0) begin
								blk_q <= blk_q - CW'(1);
							end
						end else begin
							aq_q    <= QW'(0);
							ak_q    <= K_FREE;
							state_q <= S_FA;
						end
					end
				end
				S_POP: begin
					cnt_q   <= qe.size - CW'(1);
					st_q    <= ST_OK;
					rs_q    <= s_q;
					state_q <= S_DONE;
					if (cls_q == CL_FLASH) begin
						if (fl_q != '0) begin
							fl_q <= fl_q - CW'(1);
						end
						aq_q    <= QW'(0);
						ak_q    <= K_FREE;
						state_q <= S_FA;
					end
				end
				S_FA: begin
					tail_q  <= qe.tail;
					state_q <= qe.tail[SW] ? S_DONE : S_FA2;
					if (op_q == OP_APPEND) begin
						cnt_q <= qe.size + CW'(1);
						st_q  <= ST_OK;
						rs_q  <= s_q;
						if (cls_q == CL_BUF || cls_q == CL_ROW) begin
							blk_q <= blk_q + CW'(1);
						end
						if (cls_q == CL_FLASH) begin
							fl_q <= fl_q + CW'(1);
						end
					end
				end
				S_FA2: state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

	assign rsp.result_slot       = 8'(rs_q);
	assign rsp.status            = st_q;
	assign rsp.queue_count       = 9'(cnt_q);
	assign rsp.blocked_total     = 9'(blk_q);
	assign rsp.flash_outstanding = 9'(fl_q);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("item taken but sequencer not running");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe not a single cycle");

	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.result_slot == 8'd0)
		else $error("rejected item carries a slot");

	a_fail_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK && !app_ok && !pop_go && !unl_ok |-> !nx_we && !pv_we
			&& !kd_we && !qm_we)
		else $error("rejected item wrote state");

endmodule

// ===== src/lrqm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lrqm_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/tb_linked_request_queue_manager_unit.sv =====
// Self-checking testbench of the linked request queue manager: directed table, then random items.
module tb_linked_request_queue_manager_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import lrqm_pkg::*;

	localparam int NONE_L = 999;
	localparam int NQ = 4 + 2 * CHANNELS * WAYS;
	localparam int LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy, done;
	rsp_t rsp;

	linked_request_queue_manager_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	int nxt [SLOTS];
	int prv [SLOTS];
	logic [2:0] skind [SLOTS];
	int qhd [NQ];
	int qtl [NQ];
	int qsz [NQ];
	int blk_sum, fl_pend;

	rsp_t pending_rsp [$];
	int errors = 0;
	int cycles = 0;

	// directed rows: cmd, check flag, typed-in result
	typedef struct packed {
		cmd_t c;
		logic chk;
		rsp_t r;
	} row_t;

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("mismatch %s: got %0d want %0d", what, got, want);
	endtask

	function automatic void pool_reset();
		for (int i = 0; i < SLOTS; i++) begin
			nxt[i] = (i + 1 < SLOTS) ? i + 1 : NONE_L;
			prv[i] = (i > 0) ? i - 1 : NONE_L;
			skind[i] = K_FREE;
		end
		for (int i = 0; i < NQ; i++) begin
			qhd[i] = NONE_L; qtl[i] = NONE_L; qsz[i] = 0;
		end
		qhd[0] = 0; qtl[0] = SLOTS - 1; qsz[0] = SLOTS;
		blk_sum = 0; fl_pend = 0;
	endfunction

	function automatic void link_tail(input int q, input int s);
		if (qtl[q] != NONE_L) begin
			prv[s] = qtl[q]; nxt[qtl[q]] = s;
		end else begin
			prv[s] = NONE_L; qhd[q] = s;
		end
		nxt[s] = NONE_L; qtl[q] = s; qsz[q]++;
	endfunction

	function automatic logic [2:0] class_kind(input logic [2:0] c);
		case (c)
			CL_FREE: return K_FREE;
			CL_SLICE: return K_SLICE;
			CL_BUF: return K_BUF;
			CL_ROW: return K_ROW;
			CL_DMA: return K_DMA;
			CL_FLASH: return K_FLASH;
			default: return K_NONE;
		endcase
	endfunction

	function automatic rsp_t queue_step(input cmd_t c);
		rsp_t r;
		logic qok;
		int q, s, p, n, sl;
		qok = 1'b1; q = 0; r = '0; r.status = ST_NALLOWED; sl = c.slot;
		case (c.queue_class)
			CL_FREE: q = 0;
			CL_SLICE: q = 1;
			CL_BUF: q = 2;
			CL_DMA: q = 3;
			CL_ROW, CL_FLASH: begin
				if (c.channel < CHANNELS && c.way < WAYS)
					q = ((c.queue_class == CL_ROW) ? 4 : 4 + CHANNELS * WAYS)
						+ c.channel * WAYS + c.way;
				else qok = 1'b0;
			end
			default: qok = 1'b0;
		endcase
		if (qok && c.kind == OP_APPEND) begin
			if (sl < SLOTS && skind[sl] == K_NONE) begin
				link_tail(q, sl);
				skind[sl] = class_kind(c.queue_class);
				if (c.queue_class == CL_BUF || c.queue_class == CL_ROW) blk_sum++;
				if (c.queue_class == CL_FLASH) fl_pend++;
				r.status = ST_OK; r.result_slot = 8'(sl);
			end
		end else if (qok && c.kind == OP_POP) begin
			if (c.queue_class inside {CL_FREE, CL_SLICE, CL_FLASH}) begin
				if (qhd[q] == NONE_L) r.status = ST_EMPTY;
				else begin
					s = qhd[q]; n = nxt[s];
					if (n != NONE_L) begin
						qhd[q] = n; prv[n] = NONE_L;
					end else begin
						qhd[q] = NONE_L; qtl[q] = NONE_L;
					end
					qsz[q]--;
					skind[s] = K_NONE;
					if (c.queue_class == CL_FLASH) begin
						if (fl_pend > 0) fl_pend--;
						link_tail(0, s);
						skind[s] = K_FREE;
					end
					r.status = ST_OK; r.result_slot = 8'(s);
				end
			end
		end else if (qok && c.kind == OP_UNLINK) begin
			if (c.queue_class inside {CL_BUF, CL_ROW, CL_DMA} && sl < SLOTS
				&& skind[sl] == class_kind(c.queue_class) && qsz[q] > 0
				&& (prv[sl] != NONE_L || qhd[q] == sl)
				&& (nxt[sl] != NONE_L || qtl[q] == sl)) begin
				p = prv[sl]; n = nxt[sl];
				if (p != NONE_L && n != NONE_L) begin
					nxt[p] = n; prv[n] = p;
				end else if (p != NONE_L) begin
					nxt[p] = NONE_L; qtl[q] = p;
				end else if (n != NONE_L) begin
					prv[n] = NONE_L; qhd[q] = n;
				end else begin
					qhd[q] = NONE_L; qtl[q] = NONE_L;
				end
				qsz[q]--;
				skind[sl] = K_NONE;
				if (c.queue_class != CL_DMA) begin
					if (blk_sum > 0) blk_sum--;
				end else begin
					link_tail(0, sl);
					skind[sl] = K_FREE;
				end
				r.status = ST_OK; r.result_slot = 8'(sl);
			end
		end
		r.queue_count = 9'(qok ? qsz[q] : 0);
		r.blocked_total = 9'(blk_sum);
		r.flash_outstanding = 9'(fl_pend);
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) report("unexpected result", rsp.result_slot, -1);
			else begin
				rsp_t w;
				w = pending_rsp.pop_front();
				if (rsp.result_slot !== w.result_slot)
					report("result_slot", rsp.result_slot, w.result_slot);
				if (rsp.status !== w.status) report("status", rsp.status, w.status);
				if (rsp.queue_count !== w.queue_count)
					report("queue_count", rsp.queue_count, w.queue_count);
				if (rsp.blocked_total !== w.blocked_total)
					report("blocked_total", rsp.blocked_total, w.blocked_total);
				if (rsp.flash_outstanding !== w.flash_outstanding)
					report("flash_outstanding", rsp.flash_outstanding, w.flash_outstanding);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[linked_request_queue_manager_unit] ERROR");
			$finish;
		end
	end

	task automatic issue(input cmd_t c, input logic chk, input rsp_t want);
		rsp_t p;
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd <= c;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		p = queue_step(c);
		if (chk) begin
			if (p.result_slot !== want.result_slot)
				report("table result_slot", p.result_slot, want.result_slot);
			if (p.status !== want.status) report("table status", p.status, want.status);
			if (p.queue_count !== want.queue_count)
				report("table queue_count", p.queue_count, want.queue_count);
			if (p.blocked_total !== want.blocked_total)
				report("table blocked_total", p.blocked_total, want.blocked_total);
			if (p.flash_outstanding !== want.flash_outstanding)
				report("table flash_outstanding", p.flash_outstanding,
					want.flash_outstanding);
		end
		pending_rsp.push_back(p);
		@(negedge clk);
	endtask

	function automatic cmd_t mk(input int k, input int cl, input int ch, input int w,
		input int s);
		cmd_t c;
		c.kind = 2'(k); c.queue_class = 3'(cl); c.channel = 3'(ch); c.way = 3'(w);
		c.slot = 8'(s);
		return c;
	endfunction

	function automatic rsp_t rr(input int s, input int st, input int qc, input int bt,
		input int fo);
		rsp_t r;
		r.result_slot = 8'(s); r.status = 2'(st); r.queue_count = 9'(qc);
		r.blocked_total = 9'(bt); r.flash_outstanding = 9'(fo);
		return r;
	endfunction

	row_t dir_rows [$];
	int held [$];

	initial begin
		cmd_t c;
		int pick, k, cl;
		pool_reset();
		dir_rows = '{
			'{mk(OP_POP, CL_SLICE, 0, 0, 0), 1'b1, rr(0, ST_EMPTY, 0, 0, 0)},
			'{mk(OP_POP, CL_FREE, 0, 0, 0), 1'b1, rr(0, ST_OK, 255, 0, 0)},
			'{mk(OP_POP, CL_FREE, 7, 7, 255), 1'b1, rr(1, ST_OK, 254, 0, 0)},
			'{mk(OP_POP, CL_FREE, 0, 0, 0), 1'b1, rr(2, ST_OK, 253, 0, 0)},
			'{mk(OP_POP, CL_FREE, 0, 0, 0), 1'b1, rr(3, ST_OK, 252, 0, 0)},
			'{mk(OP_APPEND, CL_FLASH, 7, 7, 0), 1'b1, rr(0, ST_OK, 1, 0, 1)},
			'{mk(OP_APPEND, CL_ROW, 0, 0, 1), 1'b1, rr(1, ST_OK, 1, 1, 1)},
			'{mk(OP_APPEND, CL_BUF, 0, 0, 2), 1'b1, rr(2, ST_OK, 1, 2, 1)},
			'{mk(OP_APPEND, CL_DMA, 0, 0, 3), 1'b1, rr(3, ST_OK, 1, 2, 1)},
			'{mk(OP_APPEND, CL_SLICE, 0, 0, 3), 1'b1, rr(0, ST_NALLOWED, 0, 2, 1)},
			'{mk(3, CL_FREE, 0, 0, 0), 1'b1, rr(0, ST_NALLOWED, 252, 2, 1)},
			'{mk(OP_POP, 7, 0, 0, 0), 1'b1, rr(0, ST_NALLOWED, 0, 2, 1)},
			'{mk(OP_POP, 6, 0, 0, 0), 1'b1, rr(0, ST_NALLOWED, 0, 2, 1)},
			'{mk(OP_POP, CL_BUF, 0, 0, 0), 1'b1, rr(0, ST_NALLOWED, 1, 2, 1)},
			'{mk(OP_UNLINK, CL_FREE, 0, 0, 4), 1'b1, rr(0, ST_NALLOWED, 252, 2, 1)},
			'{mk(OP_UNLINK, CL_ROW, 1, 0, 1), 1'b1, rr(0, ST_NALLOWED, 0, 2, 1)},
			'{mk(OP_UNLINK, CL_ROW, 0, 0, 1), 1'b1, rr(1, ST_OK, 0, 1, 1)},
			'{mk(OP_UNLINK, CL_BUF, 0, 0, 2), 1'b1, rr(2, ST_OK, 0, 0, 1)},
			'{mk(OP_UNLINK, CL_DMA, 0, 0, 3), 1'b1, rr(3, ST_OK, 0, 0, 1)},
			'{mk(OP_POP, CL_FLASH, 7, 7, 0), 1'b1, rr(0, ST_OK, 0, 0, 0)},
			'{mk(OP_POP, CL_FLASH, 7, 7, 0), 1'b1, rr(0, ST_EMPTY, 0, 0, 0)},
			'{mk(OP_UNLINK, CL_DMA, 0, 0, 3), 1'b0, '0},
			'{mk(OP_APPEND, CL_SLICE, 0, 0, 1), 1'b0, '0},
			'{mk(OP_POP, CL_SLICE, 0, 0, 0), 1'b0, '0}
		};
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_rows[i]) issue(dir_rows[i].c, dir_rows[i].chk, dir_rows[i].r);
		for (int i = 0; i < SLOTS; i++) if (skind[i] == K_NONE) held.push_back(i);
		for (int n = 0; n < 550; n++) begin
			k = $urandom_range(0, 99);
			c = mk($urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7),
				$urandom_range(0, 7), $urandom_range(0, 255));
			if (k < 10) begin
				// raw noise
			end else if (held.size() < 4 || k < 35) begin
				c.kind = OP_POP;
				c.queue_class = ($urandom_range(0, 3) == 0) ? CL_SLICE :
					(($urandom_range(0, 2) == 0) ? CL_FLASH : CL_FREE);
				c.channel = 3'($urandom_range(0, 1)); c.way = 3'($urandom_range(0, 1));
			end else if (k < 70) begin
				pick = $urandom_range(0, held.size() - 1);
				c.kind = OP_APPEND; c.slot = 8'(held[pick]);
				cl = $urandom_range(0, 5);
				c.queue_class = 3'(cl);
				c.channel = 3'($urandom_range(0, 1)); c.way = 3'($urandom_range(0, 1));
			end else begin
				c.kind = OP_UNLINK;
				c.queue_class = ($urandom_range(0, 2) == 0) ? CL_BUF :
					(($urandom_range(0, 1) == 0) ? CL_ROW : CL_DMA);
				c.channel = 3'($urandom_range(0, 1)); c.way = 3'($urandom_range(0, 1));
				if ($urandom_range(0, 3) != 0) begin
					pick = $urandom_range(0, SLOTS - 1);
					for (int j = 0; j < SLOTS; j++)
						if (skind[(pick + j) % SLOTS] == class_kind(c.queue_class)) begin
							c.slot = 8'((pick + j) % SLOTS);
							break;
						end
				end
			end
			issue(c, 1'b0, '0);
			held.delete();
			for (int i = 0; i < SLOTS; i++) if (skind[i] == K_NONE) held.push_back(i);
		end
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) $display("[linked_request_queue_manager_unit] OK");
		else $display("[linked_request_queue_manager_unit] ERROR");
		$finish;
	end
endmodule
